// ===== src/rru_pkg.sv =====
// Package: shared widths, codes and constants for the raster row unpacker.
`timescale 1ns / 1ps
`default_nettype none
package rru_pkg;

	localparam int MAX_WIDTH     = 4096;
	localparam int MAX_HEIGHT    = 4096;
	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

	localparam int WIDTH_W = 13;
	localparam int PITCH_W = 15;
	localparam int ROW_W   = 12;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		MODE_RGBA32  = 2'd0,
		MODE_RGB24   = 2'd1,
		MODE_PALETTE = 2'd2,
		MODE_BITONAL = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FG         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BG         = 3'd5;

	localparam logic [0:0] ACT_RASTER    = 1'b0;
	localparam logic [0:0] ACT_PAL_WRITE = 1'b1;

	localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
	localparam logic [7:0]  BIT_MSB      = 8'h80;

	localparam logic [WIDTH_W-1:0] RST_WIDTH  = 13'd1;
	localparam logic [PITCH_W-1:0] RST_PITCH  = 15'd4;
	localparam logic [WIDTH_W-1:0] RST_HEIGHT = 13'd1;
	localparam logic [31:0]        RST_FG     = 32'h0000_00FF;
	localparam logic [31:0]        RST_BG     = 32'hFFFF_FF00;

	// palette entry as it stands after reset
	function automatic logic [31:0] grey_word(input logic [PAL_AW-1:0] idx);
		logic [7:0] v;
		v = 8'(idx);
		return ALPHA_OPAQUE | {8'h00, v, v, v};
	endfunction

endpackage
`default_nettype wire

// ===== src/rru_pix_in_if.sv =====
// Interface: input item channel (raster byte or palette write).
`timescale 1ns / 1ps
`default_nettype none
interface rru_pix_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  data_byte;
	logic [7:0]  palette_index;
	logic [31:0] palette_word;

	modport source (output valid, output action, output data_byte, output palette_index,
		output palette_word, input ready);
	modport sink (input valid, input action, input data_byte, input palette_index,
		input palette_word, output ready);
endinterface
`default_nettype wire

// ===== src/rru_pix_out_if.sv =====
// Interface: output pixel channel.
`timescale 1ns / 1ps
`default_nettype none
interface rru_pix_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_word;
	logic        last_of_run;
	logic        row_end;
	logic        image_end;

	modport source (output valid, output pixel_word, output last_of_run, output row_end,
		output image_end, input ready);
	modport sink (input valid, input pixel_word, input last_of_run, input row_end,
		input image_end, output ready);
endinterface
`default_nettype wire

// ===== src/rru_cfg_if.sv =====
// Interface: configuration register write channel.
`timescale 1ns / 1ps
`default_nettype none
interface rru_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rru_pkg::CFG_IDX_W-1:0]  index;
	logic [31:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/raster_row_unpack_to_rgba32.sv =====
// Top level: padded raster row unpacker producing 32-bit RGBA pixels.
`timescale 1ns / 1ps
`default_nettype none
// Takes one raster byte or palette write per beat and emits pixel beats with
// red in the low byte. Raster bytes that give at most one pixel (rgba32, rgb24,
// palette, padding) and palette writes are taken one per cycle unless the output
// register is held; a bitonal byte holds the single output register until all
// its pixels (1 to 8) are taken, while a next pixel item waits in the input
// register. An input beat passes two registers to its first pixel: an input
// register that also holds the registered palette read, then the output register.
// The palette is 256 x 32 memory with a per-entry valid bit; entries never
// written read as the grey ramp, so no clearing pass is needed after reset.
// Configuration writes are always taken and must only be issued while the block is idle.
module raster_row_unpack_to_rgba32 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	rru_pix_in_if.sink       pix_in,
	rru_pix_out_if.source    pix_out,
	rru_cfg_if.sink          cfg
);

	localparam int AW = rru_pkg::PAL_AW;

	// configuration registers
	rru_pkg::mode_t                  pixel_mode_q;
	logic [rru_pkg::WIDTH_W-1:0]     image_width_q;
	logic [rru_pkg::PITCH_W-1:0]     row_pitch_q;
	logic [rru_pkg::WIDTH_W-1:0]     image_height_q;
	logic [31:0]                     fg_color_q;
	logic [31:0]                     bg_color_q;

	// row state
	logic [rru_pkg::PITCH_W-1:0]     row_pos_q;
	logic [rru_pkg::ROW_W-1:0]       row_cnt_q;
	logic [23:0]                     assembly_q;
	logic [1:0]                      phase_q;

	// palette
	logic [31:0]                     pal_mem [rru_pkg::PALETTE_DEPTH];
	logic [rru_pkg::PALETTE_DEPTH-1:0] pal_valid_q;

	// stage 1: accepted item
	logic                            valid_s1;
	logic                            action_s1;
	logic [7:0]                      byte_s1;
	logic [31:0]                     pal_rd_s1;
	logic                            pal_hit_s1;

	// stage 2: output register / bitonal expander
	logic                            valid_s2;
	logic [31:0]                     word_s2;
	logic                            bitonal_s2;
	logic [7:0]                      byte_s2;
	logic [3:0]                      cnt_s2;
	logic [2:0]                      k_s2;
	logic                            lbyte_s2;
	logic                            lrow_s2;

	logic                            in_accept;
	logic                            out_accept;
	logic                            fin_s2;
	logic                            s2_free;
	logic                            s1_adv;

	// stage 1 decode
	logic [rru_pkg::WIDTH_W-1:0]     w_sat;
	logic [rru_pkg::WIDTH_W-1:0]     h_sat;
	logic [15:0]                     payload;
	logic                            in_payload;
	logic                            last_byte;
	logic                            last_row;
	logic                            row_wrap;
	logic                            emit;
	logic [31:0]                     word_nx;
	logic [3:0]                      cnt_nx;
	logic [23:0]                     assembly_nx;
	logic [1:0]                      phase_nx;

	assign cfg.ready   = 1'b1;
	assign in_accept   = pix_in.valid && pix_in.ready;
	assign out_accept  = pix_out.valid && pix_out.ready;
	assign fin_s2      = (4'(k_s2) + 4'd1 == cnt_s2);
	assign s2_free     = !valid_s2 || (pix_out.ready && fin_s2);
	assign s1_adv      = valid_s1 && (!emit || s2_free);
	assign pix_in.ready = !valid_s1 || s1_adv;

	always_comb begin
		w_sat = (image_width_q > rru_pkg::WIDTH_W'(rru_pkg::MAX_WIDTH))
			? rru_pkg::WIDTH_W'(rru_pkg::MAX_WIDTH) : image_width_q;
		if (image_height_q == '0)
			h_sat = rru_pkg::WIDTH_W'(1);
		else if (image_height_q > rru_pkg::WIDTH_W'(rru_pkg::MAX_HEIGHT))
			h_sat = rru_pkg::WIDTH_W'(rru_pkg::MAX_HEIGHT);
		else
			h_sat = image_height_q;

		case (pixel_mode_q)
			rru_pkg::MODE_RGBA32:  payload = {1'b0, w_sat, 2'b00};
			rru_pkg::MODE_RGB24:   payload = {2'b00, w_sat, 1'b0} + 16'(w_sat);
			rru_pkg::MODE_PALETTE: payload = 16'(w_sat);
			default:               payload = 16'((16'(w_sat) + 16'd7) >> 3);
		endcase

		in_payload = 16'(row_pos_q) < payload;
		last_byte  = 16'(row_pos_q) == payload - 16'd1;
		last_row   = (14'(row_cnt_q) + 14'd1) >= 14'(h_sat);
		row_wrap   = (16'(row_pos_q) + 16'd1) >= 16'(row_pitch_q);

		emit        = 1'b0;
		word_nx     = '0;
		cnt_nx      = 4'd1;
		assembly_nx = assembly_q;
		phase_nx    = phase_q;
		if (action_s1 == rru_pkg::ACT_RASTER && in_payload) begin
			case (pixel_mode_q)
				rru_pkg::MODE_RGBA32: begin
					if (phase_q == 2'd3) begin
						emit        = 1'b1;
						word_nx     = {byte_s1, assembly_q};
						assembly_nx = '0;
						phase_nx    = '0;
					end else begin
						assembly_nx = assembly_q | (24'(byte_s1) << {phase_q, 3'b000});
						phase_nx    = phase_q + 2'd1;
					end
				end
				rru_pkg::MODE_RGB24: begin
					// phase 3 can be left over from rgba32 mode
					if (phase_q >= 2'd2) begin
						emit        = 1'b1;
						word_nx     = rru_pkg::ALPHA_OPAQUE | {8'h00, byte_s1, assembly_q[15:0]};
						assembly_nx = '0;
						phase_nx    = '0;
					end else begin
						assembly_nx = assembly_q | (24'(byte_s1) << {phase_q, 3'b000});
						phase_nx    = phase_q + 2'd1;
					end
				end
				rru_pkg::MODE_PALETTE: begin
					emit    = 1'b1;
					word_nx = pal_hit_s1 ? pal_rd_s1 : rru_pkg::grey_word(AW'(byte_s1));
				end
				default: begin
					emit   = 1'b1;
					cnt_nx = (last_byte && w_sat[2:0] != 3'd0) ? {1'b0, w_sat[2:0]} : 4'd8;
				end
			endcase
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q   <= rru_pkg::MODE_RGBA32;
			image_width_q  <= rru_pkg::RST_WIDTH;
			row_pitch_q    <= rru_pkg::RST_PITCH;
			image_height_q <= rru_pkg::RST_HEIGHT;
			fg_color_q     <= rru_pkg::RST_FG;
			bg_color_q     <= rru_pkg::RST_BG;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				rru_pkg::CFG_PIXEL_MODE: pixel_mode_q   <= rru_pkg::mode_t'(cfg.data[1:0]);
				rru_pkg::CFG_WIDTH:      image_width_q  <= cfg.data[rru_pkg::WIDTH_W-1:0];
				rru_pkg::CFG_PITCH:      row_pitch_q    <= cfg.data[rru_pkg::PITCH_W-1:0];
				rru_pkg::CFG_HEIGHT:     image_height_q <= cfg.data[rru_pkg::WIDTH_W-1:0];
				rru_pkg::CFG_FG:         fg_color_q     <= cfg.data;
				rru_pkg::CFG_BG:         bg_color_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	// palette memory: write and registered read on the input beat
	always_ff @(posedge clk) begin
		if (in_accept) begin
			if (pix_in.action == rru_pkg::ACT_PAL_WRITE)
				pal_mem[AW'(pix_in.palette_index)] <= pix_in.palette_word;
			pal_rd_s1 <= pal_mem[AW'(pix_in.data_byte)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_valid_q <= '0;
		end else if (in_accept && pix_in.action == rru_pkg::ACT_PAL_WRITE) begin
			pal_valid_q[AW'(pix_in.palette_index)] <= 1'b1;
		end
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			action_s1  <= pix_in.action;
			byte_s1    <= pix_in.data_byte;
			pal_hit_s1 <= pal_valid_q[AW'(pix_in.data_byte)];
		end
	end

	// row state update as each raster item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q  <= '0;
			row_cnt_q  <= '0;
			assembly_q <= '0;
			phase_q    <= '0;
		end else if (s1_adv && action_s1 == rru_pkg::ACT_RASTER) begin
			if (row_wrap) begin
				row_pos_q  <= '0;
				assembly_q <= '0;
				phase_q    <= '0;
				row_cnt_q  <= last_row ? '0 : row_cnt_q + 1'b1;
			end else begin
				row_pos_q  <= row_pos_q + 1'b1;
				assembly_q <= assembly_nx;
				phase_q    <= phase_nx;
			end
		end
	end

	// stage 2: output register, steps through bitonal pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			k_s2     <= '0;
		end else if (s1_adv && emit) begin
			valid_s2 <= 1'b1;
			k_s2     <= '0;
		end else if (out_accept) begin
			if (fin_s2)
				valid_s2 <= 1'b0;
			else
				k_s2 <= k_s2 + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			word_s2    <= word_nx;
			bitonal_s2 <= (pixel_mode_q == rru_pkg::MODE_BITONAL);
			byte_s2    <= byte_s1;
			cnt_s2     <= cnt_nx;
			lbyte_s2   <= last_byte;
			lrow_s2    <= last_row;
		end
	end

	assign pix_out.valid       = valid_s2;
	assign pix_out.pixel_word  = !bitonal_s2 ? word_s2
		: (((byte_s2 & (rru_pkg::BIT_MSB >> k_s2)) != 8'h00) ? fg_color_q : bg_color_q);
	assign pix_out.last_of_run = fin_s2;
	assign pix_out.row_end     = fin_s2 && lbyte_s2;
	assign pix_out.image_end   = fin_s2 && lbyte_s2 && lrow_s2;

`ifndef SYNTHESIS
	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (4'(k_s2) < cnt_s2))
		else $error("bitonal pixel index past run length");

	a_single_run: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !bitonal_s2) |-> (cnt_s2 == 4'd1))
		else $error("non-bitonal item with more than one pixel");

	a_end_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && pix_out.image_end) |-> (pix_out.row_end && pix_out.last_of_run))
		else $error("image end without row end and run end");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !(pix_out.ready && fin_s2)) |=> (valid_s2 && $stable(cnt_s2)))
		else $error("output register changed before its run finished");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_raster_row_unpack_to_rgba32.sv =====
// Testbench: directed table and random rows for the raster row unpacker, checked beat by beat.
`timescale 1ns / 1ps
`default_nettype none
module tb_raster_row_unpack_to_rgba32;

	localparam int RANDOM_ITEMS = 420;
	localparam int STALL_LIMIT  = 4000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES  = 16;

	typedef struct packed {
		logic        action;
		logic [7:0]  data_byte;
		logic [7:0]  palette_index;
		logic [31:0] palette_word;
	} in_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic        last_run;
		logic        row_end;
		logic        img_end;
	} pixel_beat_t;

	typedef enum logic [1:0] {CHK_PREDICT, CHK_ONE, CHK_NONE} row_check_t;
	typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

	typedef struct {
		row_kind_t                         kind;
		logic [rru_pkg::CFG_IDX_W-1:0]     reg_idx;
		logic [31:0]                       reg_val;
		in_item_t                          item;
		row_check_t                        chk;
		pixel_beat_t                       want;
	} stim_row_t;

	localparam pixel_beat_t NO_PIXEL = '{32'h0, 1'b0, 1'b0, 1'b0};

	logic clk;
	logic arst_n;

	rru_pix_in_if  pix_in ();
	rru_pix_out_if pix_out ();
	rru_cfg_if     cfg ();

	raster_row_unpack_to_rgba32 dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out),
		.cfg     (cfg)
	);

	// shadow copy of the block: registers, row state and palette
	rru_pkg::mode_t              reg_mode;
	logic [rru_pkg::WIDTH_W-1:0] reg_width;
	logic [rru_pkg::PITCH_W-1:0] reg_pitch;
	logic [rru_pkg::WIDTH_W-1:0] reg_height;
	logic [31:0]                 reg_fg;
	logic [31:0]                 reg_bg;
	logic [rru_pkg::PITCH_W-1:0] byte_pos;
	logic [rru_pkg::ROW_W-1:0]   row_idx;
	logic [23:0]                 gathered;
	logic [1:0]                  gather_cnt;
	logic [31:0]                 palette_copy [rru_pkg::PALETTE_DEPTH];

	pixel_beat_t fresh_pixels[$];
	pixel_beat_t expected_pixels[$];
	stim_row_t   stim_table[$];

	bit calm;
	int mismatches;
	int beats_sent;
	int pal_writes;
	int pixels_seen;
	int reg_writes;
	int random_items;
	int settings_tried;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic void push_pixel(logic [31:0] w, logic last, logic row, logic img);
		fresh_pixels.push_back('{w, last, row, img});
	endfunction

	function automatic void set_reg(logic [rru_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		case (idx)
			rru_pkg::CFG_PIXEL_MODE: reg_mode = rru_pkg::mode_t'(val[1:0]);
			rru_pkg::CFG_WIDTH:      reg_width = val[rru_pkg::WIDTH_W-1:0];
			rru_pkg::CFG_PITCH:      reg_pitch = val[rru_pkg::PITCH_W-1:0];
			rru_pkg::CFG_HEIGHT:     reg_height = val[rru_pkg::WIDTH_W-1:0];
			rru_pkg::CFG_FG:         reg_fg = val;
			rru_pkg::CFG_BG:         reg_bg = val;
			default: ;
		endcase
	endfunction

	// pixels one accepted beat produces; fills fresh_pixels
	function automatic void unpack_beat(in_item_t it);
		int unsigned w, h, payload, cnt;
		bit last_row, last_byte, fin;
		fresh_pixels.delete();
		if (it.action == rru_pkg::ACT_PAL_WRITE) begin
			palette_copy[it.palette_index] = it.palette_word;
			return;
		end
		w = (reg_width > rru_pkg::MAX_WIDTH) ? rru_pkg::MAX_WIDTH : reg_width;
		h = (reg_height == 0) ? 1 : reg_height;
		if (h > rru_pkg::MAX_HEIGHT)
			h = rru_pkg::MAX_HEIGHT;
		case (reg_mode)
			rru_pkg::MODE_RGBA32:  payload = w * 4;
			rru_pkg::MODE_RGB24:   payload = w * 3;
			rru_pkg::MODE_PALETTE: payload = w;
			default:               payload = (w + 7) / 8;
		endcase
		last_row = (row_idx + 1 >= h);
		if (byte_pos < payload) begin
			last_byte = (byte_pos == payload - 1);
			case (reg_mode)
				rru_pkg::MODE_RGBA32: begin
					if (gather_cnt >= 3) begin
						push_pixel({it.data_byte, gathered}, 1'b1, last_byte,
							last_byte && last_row);
						gathered = '0;
						gather_cnt = '0;
					end else begin
						gathered = gathered | (24'(it.data_byte) << (8 * gather_cnt));
						gather_cnt = gather_cnt + 1'b1;
					end
				end
				rru_pkg::MODE_RGB24: begin
					// a mode switch mid-row can leave three bytes gathered; only 16 bits count
					if (gather_cnt >= 2) begin
						push_pixel(rru_pkg::ALPHA_OPAQUE | {8'h00, it.data_byte, gathered[15:0]},
							1'b1, last_byte, last_byte && last_row);
						gathered = '0;
						gather_cnt = '0;
					end else begin
						gathered = gathered | (24'(it.data_byte) << (8 * gather_cnt));
						gather_cnt = gather_cnt + 1'b1;
					end
				end
				rru_pkg::MODE_PALETTE:
					push_pixel(palette_copy[it.data_byte], 1'b1, last_byte,
						last_byte && last_row);
				default: begin
					cnt = 8;
					if (last_byte && (w % 8) != 0)
						cnt = w % 8;
					for (int k = 0; k < cnt; k++) begin
						fin = (k + 1 == cnt);
						push_pixel((it.data_byte & (rru_pkg::BIT_MSB >> k)) != 0 ? reg_fg : reg_bg,
							fin, fin && last_byte, fin && last_byte && last_row);
					end
				end
			endcase
		end
		if (byte_pos + 1 >= reg_pitch) begin
			byte_pos = '0;
			gather_cnt = '0;
			gathered = '0;
			row_idx = last_row ? '0 : row_idx + 1'b1;
		end else begin
			byte_pos = byte_pos + 1'b1;
		end
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
	endtask

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_item(in_item_t it, row_check_t chk, pixel_beat_t want);
		while (!calm && $urandom_range(99) < 37) begin
			pix_in.valid <= 1'b0;
			@(negedge clk);
		end
		pix_in.valid         <= 1'b1;
		pix_in.action        <= it.action;
		pix_in.data_byte     <= it.data_byte;
		pix_in.palette_index <= it.palette_index;
		pix_in.palette_word  <= it.palette_word;
		@(posedge clk);
		while (!pix_in.ready)
			@(posedge clk);
		unpack_beat(it);
		case (chk)
			CHK_PREDICT: foreach (fresh_pixels[i]) expected_pixels.push_back(fresh_pixels[i]);
			CHK_ONE:     expected_pixels.push_back(want);
			default: ;
		endcase
		beats_sent++;
		if (it.action == rru_pkg::ACT_PAL_WRITE)
			pal_writes++;
		@(negedge clk);
	endtask

	// sender goes quiet and waits until every pixel has come out
	task automatic settle();
		pix_in.valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// leaves cfg.valid high; the caller drops it after the last write of a group
	task automatic write_reg(logic [rru_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		set_reg(idx, val);
		reg_writes++;
		@(negedge clk);
	endtask

	function automatic stim_row_t cfg_row(logic [rru_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		stim_row_t r;
		r = '{ROW_CFG, idx, val, '0, CHK_NONE, NO_PIXEL};
		return r;
	endfunction

	function automatic stim_row_t byte_row(logic [7:0] b, row_check_t chk, pixel_beat_t want);
		stim_row_t r;
		r = '{ROW_BEAT, '0, '0, '{rru_pkg::ACT_RASTER, b, 8'h00, 32'h0}, chk, want};
		return r;
	endfunction

	function automatic pixel_beat_t px(logic [31:0] w, logic last, logic row, logic img);
		pixel_beat_t p;
		p = '{w, last, row, img};
		return p;
	endfunction

	// output side: random back-pressure and beat checking
	always @(negedge clk)
		pix_out.ready <= calm || ($urandom_range(99) >= 37);

	always @(posedge clk) begin
		pixel_beat_t want;
		if (pix_out.valid && pix_out.ready) begin
			pixels_seen++;
			if (expected_pixels.size() == 0) begin
				report_mismatch("pixel with nothing pending", pix_out.pixel_word, 32'h0);
			end else begin
				want = expected_pixels.pop_front();
				if (pix_out.pixel_word !== want.word)
					report_mismatch("pixel_word", pix_out.pixel_word, want.word);
				if (pix_out.last_of_run !== want.last_run)
					report_mismatch("last_of_run", 32'(pix_out.last_of_run), 32'(want.last_run));
				if (pix_out.row_end !== want.row_end)
					report_mismatch("row_end", 32'(pix_out.row_end), 32'(want.row_end));
				if (pix_out.image_end !== want.img_end)
					report_mismatch("image_end", 32'(pix_out.image_end), 32'(want.img_end));
			end
		end
	end

	// watchdog: too many cycles with no beat on any channel ends the run
	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
				(cfg.valid && cfg.ready))
				stall = 0;
			else
				stall++;
		end
		$display("watchdog: no beat for %0d cycles, %0d pixels pending", STALL_LIMIT,
			expected_pixels.size());
		$display("[raster_row_unpack_to_rgba32] ERROR");
		$finish;
	end

	initial begin : main_seq
		stim_row_t   r;
		in_item_t    it;
		int unsigned mode_v, w_v, p_v, h_v, pay, n_bytes, pick, phase_no;
		logic [31:0] fg_v, bg_v;
		bit          cfg_open;

		arst_n = 1'b0;
		calm = 1'b0;
		pix_in.valid = 1'b0;
		pix_in.action = rru_pkg::ACT_RASTER;
		pix_in.data_byte = '0;
		pix_in.palette_index = '0;
		pix_in.palette_word = '0;
		cfg.valid = 1'b0;
		cfg.index = rru_pkg::CFG_PIXEL_MODE;
		cfg.data = '0;
		mismatches = 0;
		beats_sent = 0;
		pal_writes = 0;
		pixels_seen = 0;
		reg_writes = 0;
		random_items = 0;
		settings_tried = 0;

		reg_mode = rru_pkg::MODE_RGBA32;
		reg_width = rru_pkg::RST_WIDTH;
		reg_pitch = rru_pkg::RST_PITCH;
		reg_height = rru_pkg::RST_HEIGHT;
		reg_fg = rru_pkg::RST_FG;
		reg_bg = rru_pkg::RST_BG;
		byte_pos = '0;
		row_idx = '0;
		gathered = '0;
		gather_cnt = '0;
		for (int i = 0; i < rru_pkg::PALETTE_DEPTH; i++)
			palette_copy[i] = rru_pkg::ALPHA_OPAQUE | {8'h00, 8'(i), 8'(i), 8'(i)};

		// reset settings: one rgba32 pixel per four-byte row, a one-row image
		stim_table.push_back(byte_row(8'h11, CHK_NONE, NO_PIXEL));
		stim_table.push_back(byte_row(8'h22, CHK_NONE, NO_PIXEL));
		stim_table.push_back(byte_row(8'h33, CHK_NONE, NO_PIXEL));
		stim_table.push_back(byte_row(8'h44, CHK_ONE, px(32'h4433_2211, 1, 1, 1)));
		r = '{ROW_BEAT, '0, '0, '{rru_pkg::ACT_PAL_WRITE, 8'h5C, 8'hFF, 32'h1234_5678},
			CHK_NONE, NO_PIXEL};
		stim_table.push_back(r);
		// palette mode, two rows of two pixels and one pad byte
		stim_table.push_back(cfg_row(rru_pkg::CFG_PIXEL_MODE, 32'(rru_pkg::MODE_PALETTE)));
		stim_table.push_back(cfg_row(rru_pkg::CFG_WIDTH, 32'd2));
		stim_table.push_back(cfg_row(rru_pkg::CFG_PITCH, 32'd3));
		stim_table.push_back(cfg_row(rru_pkg::CFG_HEIGHT, 32'd2));
		stim_table.push_back(byte_row(8'hFF, CHK_ONE, px(32'h1234_5678, 1, 0, 0)));
		stim_table.push_back(byte_row(8'h00, CHK_ONE, px(32'hFF00_0000, 1, 1, 0)));
		stim_table.push_back(byte_row(8'hAB, CHK_NONE, NO_PIXEL));
		stim_table.push_back(byte_row(8'h80, CHK_ONE, px(32'hFF80_8080, 1, 0, 0)));
		stim_table.push_back(byte_row(8'h01, CHK_ONE, px(32'hFF01_0101, 1, 1, 1)));
		stim_table.push_back(byte_row(8'h00, CHK_NONE, NO_PIXEL));
		// bitonal with a partial last byte, extreme colors
		stim_table.push_back(cfg_row(rru_pkg::CFG_PIXEL_MODE, 32'(rru_pkg::MODE_BITONAL)));
		stim_table.push_back(cfg_row(rru_pkg::CFG_WIDTH, 32'd11));
		stim_table.push_back(cfg_row(rru_pkg::CFG_PITCH, 32'd2));
		stim_table.push_back(cfg_row(rru_pkg::CFG_HEIGHT, 32'd1));
		stim_table.push_back(cfg_row(rru_pkg::CFG_FG, 32'hFFFF_FFFF));
		stim_table.push_back(cfg_row(rru_pkg::CFG_BG, 32'h0000_0000));
		stim_table.push_back(byte_row(8'hA5, CHK_PREDICT, NO_PIXEL));
		stim_table.push_back(byte_row(8'hFF, CHK_PREDICT, NO_PIXEL));
		// zero width: rows still step by the pitch
		stim_table.push_back(cfg_row(rru_pkg::CFG_WIDTH, 32'd0));
		stim_table.push_back(byte_row(8'h5A, CHK_NONE, NO_PIXEL));
		stim_table.push_back(byte_row(8'h3C, CHK_NONE, NO_PIXEL));
		// width past max, zero pitch, zero height: every byte is a row of its own
		stim_table.push_back(cfg_row(rru_pkg::CFG_PIXEL_MODE, 32'(rru_pkg::MODE_RGB24)));
		stim_table.push_back(cfg_row(rru_pkg::CFG_WIDTH, 32'd8191));
		stim_table.push_back(cfg_row(rru_pkg::CFG_PITCH, 32'd0));
		stim_table.push_back(cfg_row(rru_pkg::CFG_HEIGHT, 32'd0));
		stim_table.push_back(byte_row(8'hFF, CHK_NONE, NO_PIXEL));
		// pitch shorter than payload, height past max: row cut with no row_end
		stim_table.push_back(cfg_row(rru_pkg::CFG_WIDTH, 32'd2));
		stim_table.push_back(cfg_row(rru_pkg::CFG_PITCH, 32'd5));
		stim_table.push_back(cfg_row(rru_pkg::CFG_HEIGHT, 32'd8191));
		stim_table.push_back(byte_row(8'h01, CHK_NONE, NO_PIXEL));
		stim_table.push_back(byte_row(8'h02, CHK_NONE, NO_PIXEL));
		stim_table.push_back(byte_row(8'h03, CHK_ONE, px(32'hFF03_0201, 1, 0, 0)));
		stim_table.push_back(byte_row(8'h04, CHK_NONE, NO_PIXEL));
		stim_table.push_back(byte_row(8'h05, CHK_NONE, NO_PIXEL));
		// row counter left past a shrunk height, then rgba32 -> rgb24 switch mid-pixel
		stim_table.push_back(cfg_row(rru_pkg::CFG_HEIGHT, 32'd1));
		stim_table.push_back(cfg_row(rru_pkg::CFG_PIXEL_MODE, 32'(rru_pkg::MODE_RGBA32)));
		stim_table.push_back(cfg_row(rru_pkg::CFG_WIDTH, 32'd1));
		stim_table.push_back(cfg_row(rru_pkg::CFG_PITCH, 32'd4));
		stim_table.push_back(byte_row(8'h10, CHK_NONE, NO_PIXEL));
		stim_table.push_back(byte_row(8'h20, CHK_NONE, NO_PIXEL));
		stim_table.push_back(cfg_row(rru_pkg::CFG_PIXEL_MODE, 32'(rru_pkg::MODE_RGB24)));
		stim_table.push_back(byte_row(8'h30, CHK_ONE, px(32'hFF30_2010, 1, 1, 1)));
		stim_table.push_back(byte_row(8'h40, CHK_NONE, NO_PIXEL));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		cfg_open = 1'b0;
		foreach (stim_table[i]) begin
			r = stim_table[i];
			if (r.kind == ROW_CFG) begin
				if (!cfg_open)
					settle();
				write_reg(r.reg_idx, r.reg_val);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open)
					cfg.valid <= 1'b0;
				cfg_open = 1'b0;
				send_item(r.item, r.chk, r.want);
			end
		end

		// random settings, each followed by up to three rows of random bytes and palette writes
		phase_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			calm = (phase_no >= 4 && phase_no < 8);
			settle();
			mode_v = $urandom_range(3);
			if (phase_no > 0 && $urandom_range(99) < 20) begin
				// mode only: position and gathered bytes carry over
				write_reg(rru_pkg::CFG_PIXEL_MODE, mode_v);
			end else begin
				pick = $urandom_range(99);
				if (pick < 6)
					w_v = 0;
				else if (pick < 10)
					w_v = 8191;
				else if (pick < 14)
					w_v = 4096;
				else
					w_v = $urandom_range(1, 24);
				case (rru_pkg::mode_t'(mode_v))
					rru_pkg::MODE_RGBA32:  pay = w_v * 4;
					rru_pkg::MODE_RGB24:   pay = w_v * 3;
					rru_pkg::MODE_PALETTE: pay = w_v;
					default:               pay = (w_v + 7) / 8;
				endcase
				pick = $urandom_range(99);
				if (w_v > 24)
					p_v = $urandom_range(1, 6);
				else if (pick < 8)
					p_v = 0;
				else if (pick < 13)
					p_v = 32767;
				else if (pick < 23)
					p_v = (pay > 1) ? pay - 1 : 1;
				else
					p_v = pay + $urandom_range(0, 3);
				pick = $urandom_range(99);
				if (pick < 6)
					h_v = 0;
				else if (pick < 10)
					h_v = 8191;
				else
					h_v = $urandom_range(1, 4);
				pick = $urandom_range(99);
				if (pick < 10) begin
					fg_v = 32'h0000_0000;
					bg_v = 32'hFFFF_FFFF;
				end else if (pick < 20) begin
					fg_v = 32'hFFFF_FFFF;
					bg_v = 32'h0000_0000;
				end else begin
					fg_v = $urandom;
					bg_v = $urandom;
				end
				write_reg(rru_pkg::CFG_PIXEL_MODE, mode_v);
				write_reg(rru_pkg::CFG_WIDTH, w_v);
				write_reg(rru_pkg::CFG_PITCH, p_v);
				write_reg(rru_pkg::CFG_HEIGHT, h_v);
				write_reg(rru_pkg::CFG_FG, fg_v);
				write_reg(rru_pkg::CFG_BG, bg_v);
			end
			cfg.valid <= 1'b0;
			settings_tried++;

			n_bytes = ((reg_pitch == 0) ? 1 : reg_pitch) * $urandom_range(1, 3);
			if (n_bytes > 160)
				n_bytes = 160;
			for (int b = 0; b < n_bytes && random_items < RANDOM_ITEMS; b++) begin
				if ($urandom_range(99) < 8) begin
					it = '{rru_pkg::ACT_PAL_WRITE, 8'($urandom), 8'($urandom), $urandom};
					send_item(it, CHK_PREDICT, NO_PIXEL);
				end
				it = '{rru_pkg::ACT_RASTER, 8'($urandom), 8'($urandom), $urandom};
				send_item(it, CHK_PREDICT, NO_PIXEL);
				random_items++;
				if ($urandom_range(199) == 0)
					settle();
			end
			phase_no++;
		end
		calm = 1'b0;
		pix_in.valid <= 1'b0;

		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_pixels.size() != 0)
			report_mismatch("pixels never produced", 32'(expected_pixels.size()), 32'h0);

		$display("run: %0d input beats (%0d palette writes), %0d pixel beats checked",
			beats_sent, pal_writes, pixels_seen);
		$display("run: %0d register writes, %0d random settings, %0d mismatches",
			reg_writes, settings_tried, mismatches);
		if (mismatches == 0)
			$display("[raster_row_unpack_to_rgba32] OK");
		else
			$display("[raster_row_unpack_to_rgba32] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
